// ===== hw/rtl/tac_pkg.sv =====
// Shared types, register map and constants of the touchscreen ADC controller.
package tac_pkg;

    localparam int unsigned DEF_POINTER_BITS = 15;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned COUNT_W  = 24;
    localparam int unsigned SCALE_W  = 12;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [COUNT_W-1:0] TICKS_PER_MS = 24'd66000;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_POINTER = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    // register map
    localparam logic [5:0] OFF_ADC_CON  = 6'h00;
    localparam logic [5:0] OFF_TSC_CON  = 6'h04;
    localparam logic [5:0] OFF_DELAY    = 6'h08;
    localparam logic [5:0] OFF_DATX     = 6'h0C;
    localparam logic [5:0] OFF_DATY     = 6'h10;
    localparam logic [5:0] OFF_PEN_STAT = 6'h14;
    localparam logic [5:0] OFF_ADC_CLR  = 6'h18;
    localparam logic [5:0] OFF_MUX      = 6'h1C;
    localparam logic [5:0] OFF_PEN_CLR  = 6'h20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_LAYOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_BITS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y      = 3'd5;

    localparam logic [3:0]         RES_BITS_RESET = 4'd12;
    localparam logic [3:0]         RES_BITS_MAX   = 4'd12;
    localparam logic [SCALE_W-1:0] MAX_X_RESET    = 12'd480;
    localparam logic [SCALE_W-1:0] MAX_Y_RESET    = 12'd800;

    localparam logic [WORD_W-1:0] ADC_CON_RESET = 32'h0000_3FC4;
    localparam logic [WORD_W-1:0] TSC_CON_RESET = 32'h0000_0058;
    localparam logic [WORD_W-1:0] DELAY_RESET   = 32'h0000_00FF;

    // adc_control bits
    localparam int unsigned AC_ENABLE     = 0;
    localparam int unsigned AC_READ_START = 1;
    localparam int unsigned AC_STANDBY    = 2;
    localparam int unsigned AC_PRESC_LO   = 6;
    localparam int unsigned AC_PRESC_HI   = 13;
    localparam int unsigned AC_PRESC_EN   = 14;
    localparam int unsigned AC_DONE       = 15;

    // touch_control bits
    localparam int unsigned TC_AUTO    = 2;
    localparam int unsigned TC_UP_SENSE = 8;
    localparam logic [1:0]  WAIT_MODE  = 2'd3;

    // pen_status bits
    localparam int unsigned PS_DOWN = 0;
    localparam int unsigned PS_UP   = 1;

    // control group handed from the register block to the read pipeline
    typedef struct packed {
        logic               is_data;
        logic               invert;
        logic [SCALE_W-1:0] full;
        logic [3:0]         upper;
        logic [WORD_W-1:0]  rdata;
        logic               adc_irq;
        logic               pen_irq;
        logic               bad;
    } rd_ctrl_t;

endpackage

// ===== hw/rtl/touch_adc_controller.sv =====
// Top level of the touchscreen ADC controller: register block, pen and conversion logic.
// One request is accepted per cycle while no result waits on m_ready; its result passes
// operand, product and quotient-estimate stages, then correction into the output register.
// The pipeline stalls as a whole only while a result waits on m_ready.
// Synchronous active-low reset loads all register defaults and empties the pipeline.
module touch_adc_controller
    import tac_pkg::*;
#(
    parameter int unsigned POINTER_BITS = DEF_POINTER_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [SCALE_W-1:0]      cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_operation,
    input  logic [5:0]              s_offset,
    input  logic [WORD_W-1:0]       s_write_data,
    input  logic [POINTER_BITS-1:0] s_pointer_x,
    input  logic [POINTER_BITS-1:0] s_pointer_y,
    input  logic                    s_pen_pressed,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [WORD_W-1:0]       m_read_data,
    output logic                    m_adc_irq,
    output logic                    m_pen_irq,
    output logic                    m_bad_offset
);

    // configuration
    logic               new_layout_reg;
    logic [3:0]         res_bits_reg;
    logic [SCALE_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;

    // register block state
    logic [WORD_W-1:0]       adc_con_reg, adc_con_next;
    logic [WORD_W-1:0]       tsc_con_reg, tsc_con_next;
    logic [WORD_W-1:0]       delay_reg, delay_next;
    logic [WORD_W-1:0]       pen_stat_reg, pen_stat_next;
    logic [WORD_W-1:0]       mux_reg, mux_next;
    logic [POINTER_BITS-1:0] held_x_reg, held_x_next;
    logic [POINTER_BITS-1:0] held_y_reg, held_y_next;
    logic                    pen_now_reg, pen_now_next;
    logic                    pen_rep_reg, pen_rep_next;
    logic                    adc_irq_reg, adc_irq_next;
    logic                    pen_irq_reg, pen_irq_next;
    logic [COUNT_W-1:0]      conv_len_reg, conv_len_next;
    logic [COUNT_W-1:0]      countdown_reg, countdown_next;
    logic                    cd_active_reg, cd_active_next;

    logic               adv;
    logic               accept;
    op_t                op;
    logic               start_req;
    logic [COUNT_W-1:0] start_len;
    logic               complete_req;
    logic               len_upd;
    logic [8:0]         prescale;
    logic [24:0]        len_prod;
    logic               is_data;
    logic               read_y;
    logic               bad;
    logic [WORD_W-1:0]  rdata;
    logic               sel_x;
    logic [3:0]         res_eff;
    logic [SCALE_W:0]   full_ext;
    rd_ctrl_t           ctrl;
    logic [POINTER_BITS-1:0] pos;
    logic [SCALE_W-1:0] lo, hi;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;
    assign op      = op_t'(s_operation);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            new_layout_reg <= 1'b0;
            res_bits_reg   <= RES_BITS_RESET;
            min_x_reg      <= '0;
            max_x_reg      <= MAX_X_RESET;
            min_y_reg      <= '0;
            max_y_reg      <= MAX_Y_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NEW_LAYOUT: new_layout_reg <= cfg_wr_data[0];
                CFG_RES_BITS:   res_bits_reg   <= cfg_wr_data[3:0];
                CFG_MIN_X:      min_x_reg      <= cfg_wr_data;
                CFG_MAX_X:      max_x_reg      <= cfg_wr_data;
                CFG_MIN_Y:      min_y_reg      <= cfg_wr_data;
                CFG_MAX_Y:      max_y_reg      <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        adc_con_next   = adc_con_reg;
        tsc_con_next   = tsc_con_reg;
        delay_next     = delay_reg;
        pen_stat_next  = pen_stat_reg;
        mux_next       = mux_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        pen_now_next   = pen_now_reg;
        pen_rep_next   = pen_rep_reg;
        adc_irq_next   = adc_irq_reg;
        pen_irq_next   = pen_irq_reg;
        countdown_next = countdown_reg;
        cd_active_next = cd_active_reg;
        start_req      = 1'b0;
        start_len      = conv_len_reg;
        complete_req   = 1'b0;
        len_upd        = 1'b0;
        is_data        = 1'b0;
        read_y         = 1'b0;
        bad            = 1'b0;
        rdata          = '0;

        unique case (op)
            OP_READ: begin
                unique case (s_offset)
                    OFF_ADC_CON:  rdata = adc_con_reg;
                    OFF_TSC_CON:  rdata = tsc_con_reg;
                    OFF_DELAY:    rdata = delay_reg;
                    OFF_DATX, OFF_DATY: begin
                        is_data   = 1'b1;
                        read_y    = (s_offset == OFF_DATY);
                        start_req = adc_con_reg[AC_READ_START];
                    end
                    OFF_PEN_STAT: rdata = pen_stat_reg;
                    OFF_ADC_CLR:  rdata = '0;
                    OFF_MUX:      rdata = mux_reg;
                    OFF_PEN_CLR:  rdata = '0;
                    default:      bad = 1'b1;
                endcase
            end
            OP_WRITE: begin
                unique case (s_offset)
                    OFF_ADC_CON: begin
                        // done flag is read-only
                        adc_con_next          = s_write_data;
                        adc_con_next[AC_DONE] = adc_con_reg[AC_DONE];
                        start_req = !s_write_data[AC_READ_START] && s_write_data[AC_ENABLE];
                        adc_con_next[AC_ENABLE] = 1'b0;
                        len_upd = 1'b1;
                    end
                    OFF_TSC_CON: begin
                        tsc_con_next = s_write_data;
                        if (pen_rep_reg != pen_now_reg && s_write_data[1:0] == WAIT_MODE) begin
                            start_req = 1'b1;
                            start_len = TICKS_PER_MS;
                        end
                    end
                    OFF_DELAY: begin
                        delay_next = s_write_data;
                        len_upd    = 1'b1;
                    end
                    OFF_PEN_STAT: pen_stat_next = s_write_data;
                    OFF_ADC_CLR:  adc_irq_next  = 1'b0;
                    OFF_MUX:      mux_next      = s_write_data;
                    OFF_PEN_CLR:  pen_irq_next  = 1'b0;
                    default:      bad = 1'b1;
                endcase
            end
            OP_POINTER: begin
                if (s_pen_pressed) begin
                    held_x_next = s_pointer_x;
                    held_y_next = s_pointer_y;
                end
                if (pen_now_reg != s_pen_pressed) begin
                    pen_now_next = s_pen_pressed;
                    complete_req = (tsc_con_reg[1:0] == WAIT_MODE) && !adc_con_reg[AC_STANDBY];
                end
            end
            OP_TICK: begin
                if (cd_active_reg) begin
                    if (countdown_reg <= COUNT_W'(1)) begin
                        countdown_next = '0;
                        cd_active_next = 1'b0;
                        complete_req   = 1'b1;
                    end else begin
                        countdown_next = countdown_reg - 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // conversion start is ignored in standby; reload cancels any pending countdown
        if (start_req && !adc_con_next[AC_STANDBY]) begin
            adc_con_next[AC_DONE] = 1'b0;
            countdown_next        = start_len;
            cd_active_next        = 1'b1;
        end

        if (complete_req) begin
            adc_con_next[AC_DONE] = 1'b1;
            if (tsc_con_next[1:0] != WAIT_MODE) begin
                adc_irq_next = 1'b1;
            end else begin
                if (pen_rep_reg != pen_now_next && pen_now_next != tsc_con_next[TC_UP_SENSE]) begin
                    pen_irq_next = 1'b1;
                    if (pen_now_next)
                        pen_stat_next[PS_DOWN] = 1'b1;
                    else
                        pen_stat_next[PS_UP] = 1'b1;
                end
                pen_rep_next = pen_now_next;
            end
        end
    end

    // conversion length from the values after this write
    always_comb begin
        prescale = adc_con_next[AC_PRESC_EN]
                 ? ({1'b0, adc_con_next[AC_PRESC_HI:AC_PRESC_LO]} + 9'd1) : 9'd1;
        len_prod      = 25'(delay_next[15:0]) * 25'(prescale);
        conv_len_next = len_upd ? len_prod[COUNT_W-1:0] : conv_len_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adc_con_reg   <= ADC_CON_RESET;
            tsc_con_reg   <= TSC_CON_RESET;
            delay_reg     <= DELAY_RESET;
            pen_stat_reg  <= '0;
            mux_reg       <= '0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            pen_now_reg   <= 1'b0;
            pen_rep_reg   <= 1'b0;
            adc_irq_reg   <= 1'b0;
            pen_irq_reg   <= 1'b0;
            conv_len_reg  <= '0;
            countdown_reg <= '0;
            cd_active_reg <= 1'b0;
        end else if (accept) begin
            adc_con_reg   <= adc_con_next;
            tsc_con_reg   <= tsc_con_next;
            delay_reg     <= delay_next;
            pen_stat_reg  <= pen_stat_next;
            mux_reg       <= mux_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            pen_now_reg   <= pen_now_next;
            pen_rep_reg   <= pen_rep_next;
            adc_irq_reg   <= adc_irq_next;
            pen_irq_reg   <= pen_irq_next;
            conv_len_reg  <= conv_len_next;
            countdown_reg <= countdown_next;
            cd_active_reg <= cd_active_next;
        end
    end

    // data read operands: new layout swaps axes and inverts against full scale
    always_comb begin
        sel_x    = new_layout_reg ? read_y : !read_y;
        pos      = sel_x ? held_x_reg : held_y_reg;
        lo       = sel_x ? min_x_reg : min_y_reg;
        hi       = sel_x ? max_x_reg : max_y_reg;
        res_eff  = (res_bits_reg > RES_BITS_MAX) ? RES_BITS_MAX : res_bits_reg;
        full_ext = ((SCALE_W+1)'(1) << res_eff) - (SCALE_W+1)'(1);

        ctrl.is_data = is_data;
        ctrl.invert  = new_layout_reg;
        ctrl.full    = full_ext[SCALE_W-1:0];
        ctrl.upper   = {!pen_rep_reg, tsc_con_reg[TC_AUTO], tsc_con_reg[1:0]};
        ctrl.rdata   = rdata;
        ctrl.adc_irq = adc_irq_next;
        ctrl.pen_irq = pen_irq_next;
        ctrl.bad     = bad;
    end

    tac_read_pipe #(
        .POINTER_BITS (POINTER_BITS)
    ) u_read_pipe (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .adv            (adv),
        .load           (accept),
        .in_ctrl        (ctrl),
        .in_pos         (pos),
        .in_lo          (lo),
        .in_hi          (hi),
        .out_valid      (m_valid),
        .out_read_data  (m_read_data),
        .out_adc_irq    (m_adc_irq),
        .out_pen_irq    (m_pen_irq),
        .out_bad_offset (m_bad_offset)
    );

endmodule

// ===== hw/rtl/tac_read_pipe.sv =====
// Result pipeline: scales the held position for data reads and registers the result.
module tac_read_pipe
    import tac_pkg::*;
#(
    parameter int unsigned POINTER_BITS = DEF_POINTER_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    load,
    input  rd_ctrl_t                in_ctrl,
    input  logic [POINTER_BITS-1:0] in_pos,
    input  logic [SCALE_W-1:0]      in_lo,
    input  logic [SCALE_W-1:0]      in_hi,
    output logic                    out_valid,
    output logic [WORD_W-1:0]       out_read_data,
    output logic                    out_adc_irq,
    output logic                    out_pen_irq,
    output logic                    out_bad_offset
);

    localparam int unsigned PB  = POINTER_BITS;
    localparam int unsigned NW  = PB + SCALE_W;     // product width
    localparam int unsigned QW  = NW + 1 - PB;      // estimate width
    localparam int unsigned PW1 = PB + 1;
    localparam logic [PB:0] FULL_W = PW1'((1 << PB) - 1);

    // stage 1: operands
    logic                    v1_reg;
    rd_ctrl_t                c1_reg;
    logic [PB-1:0]           pos1_reg;
    logic [SCALE_W-1:0]      absd1_reg;
    logic                    neg1_reg;
    logic [SCALE_W-1:0]      lo1_reg;
    // stage 2: product
    logic                    v2_reg;
    rd_ctrl_t                c2_reg;
    logic [NW-1:0]           n2_reg;
    logic                    neg2_reg;
    logic [SCALE_W-1:0]      lo2_reg;
    // stage 3: quotient estimate
    logic                    v3_reg;
    rd_ctrl_t                c3_reg;
    logic [NW-1:0]           n3_reg;
    logic [QW-1:0]           q3_reg;
    logic                    neg3_reg;
    logic [SCALE_W-1:0]      lo3_reg;
    // output register
    logic                    vo_reg;
    logic [WORD_W-1:0]       rd_reg;
    logic                    adc_irq_reg;
    logic                    pen_irq_reg;
    logic                    bad_reg;

    logic [SCALE_W:0]   diff;
    logic [SCALE_W:0]   diff_mag;
    logic [NW:0]        est_sum;
    logic [NW:0]        rem;
    logic [QW-1:0]      q_fix;
    logic [SCALE_W-1:0] val;
    logic [SCALE_W-1:0] word_val;
    logic [WORD_W-1:0]  rd_next;

    always_comb begin
        diff     = {1'b0, in_hi} - {1'b0, in_lo};
        diff_mag = diff[SCALE_W] ? (~diff + 1'b1) : diff;
    end

    // floor(n / (2^PB - 1)) via series; estimate is low by at most one
    always_comb begin
        est_sum = {1'b0, n2_reg} + (NW+1)'(n2_reg >> PB) + (NW+1)'(n2_reg >> (2 * PB))
                + (NW+1)'(n2_reg >> (3 * PB));
    end

    always_comb begin
        rem      = {1'b0, n3_reg} - {q3_reg, {PB{1'b0}}} + (NW+1)'(q3_reg);
        q_fix    = q3_reg + QW'(rem[PB:0] >= FULL_W);
        val      = neg3_reg ? (lo3_reg - q_fix[SCALE_W-1:0]) : (lo3_reg + q_fix[SCALE_W-1:0]);
        word_val = c3_reg.invert ? (c3_reg.full - val) : val;
        rd_next  = c3_reg.is_data ? {16'd0, c3_reg.upper, word_val} : c3_reg.rdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= load;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_reg    <= in_ctrl;
            pos1_reg  <= in_pos;
            absd1_reg <= diff_mag[SCALE_W-1:0];
            neg1_reg  <= diff[SCALE_W];
            lo1_reg   <= in_lo;

            c2_reg    <= c1_reg;
            n2_reg    <= NW'(pos1_reg) * NW'(absd1_reg);
            neg2_reg  <= neg1_reg;
            lo2_reg   <= lo1_reg;

            c3_reg    <= c2_reg;
            n3_reg    <= n2_reg;
            q3_reg    <= est_sum[NW:PB];
            neg3_reg  <= neg2_reg;
            lo3_reg   <= lo2_reg;

            rd_reg      <= rd_next;
            adc_irq_reg <= c3_reg.adc_irq;
            pen_irq_reg <= c3_reg.pen_irq;
            bad_reg     <= c3_reg.bad;
        end
    end

    assign out_valid      = vo_reg;
    assign out_read_data  = rd_reg;
    assign out_adc_irq    = adc_irq_reg;
    assign out_pen_irq    = pen_irq_reg;
    assign out_bad_offset = bad_reg;

endmodule

// ===== hw/rtl/tac_checker.sv =====
// Port-level checks of the touchscreen ADC controller, bound to the top level.
module tac_checker
    import tac_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [WORD_W-1:0] m_read_data,
    input logic              m_adc_irq,
    input logic              m_pen_irq,
    input logic              m_bad_offset
);

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // with no result waiting the block always takes a request
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a bad offset never returns data
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_offset |-> m_read_data == '0)
        else $error("bad offset with nonzero read data");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_adc_irq)
                                && $stable(m_pen_irq) && $stable(m_bad_offset))
        else $error("stalled result changed");

endmodule

bind touch_adc_controller tac_checker u_tac_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_data  (m_read_data),
    .m_adc_irq    (m_adc_irq),
    .m_pen_irq    (m_pen_irq),
    .m_bad_offset (m_bad_offset)
);
